/* rtl/mio_pkg.sv */
// shared types and constants of the mutual inhibition oscillator step block
package mio_pkg;

    localparam int FRAC          = 12;
    localparam int ONE_Q         = 4096;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_MUTUAL_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPT_GAIN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TONIC_DRIVE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_GAIN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_OVER_T1  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_OVER_T2  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_PHASE   = 3'd6;

    // register reset values
    localparam logic [14:0]        RST_MUTUAL_WEIGHT = 15'd8192;
    localparam logic [14:0]        RST_ADAPT_GAIN    = 15'd10240;
    localparam logic signed [15:0] RST_TONIC_DRIVE   = 16'sd4096;
    localparam logic signed [15:0] RST_FEEDBACK_GAIN = 16'sd0;
    localparam logic [11:0]        RST_STEP_OVER_T1  = 12'd410;
    localparam logic [11:0]        RST_STEP_OVER_T2  = 12'd205;

    typedef struct packed {
        logic               restart;
        logic signed [15:0] feedback_one;
        logic signed [15:0] feedback_two;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        step_index;
        logic [14:0]        output_one;
        logic [14:0]        output_two;
        logic signed [15:0] output_difference;
        logic               phase_bit;
        logic               saturated;
    } t_out_item;

endpackage

/* rtl/mutual_inhibition_oscillator_step.sv */
// two-neuron mutual inhibition oscillator, one euler step per tick, bit-serial datapath
//
// usage
//   input channel (i_in_valid, o_in_stall, i_in_data): one tick per transfer; a tick
//   with restart set reloads the start state picked by start_phase, any other tick
//   advances both neurons by one step using the feedback values it carries
//   output channel (o_out_valid, i_out_stall, o_out_data): one result per tick, giving
//   the outputs held before the step, their difference, the phase bit, the step
//   number and whether any membrane or adaptation update clipped
//   configuration port (i_cfg_we, i_cfg_index, i_cfg_data): write only while idle
// timing
//   a step tick runs ten products through one shift-add multiplier that takes one
//   bit of the register operand per cycle (70 bits per neuron), each product after
//   a load state, with a writeback after the membrane and the adaptation product
//   of each neuron; no new tick is taken until the result has moved to the output
//   register, and a restart tick goes straight from idle to the result state
//   a finished result waits in the output register while the receiver stalls, and
//   the next tick is taken and worked on meanwhile; it then waits for the register
// reset
//   synchronous active-low reset loads the register defaults and the start state
//   with the first neuron at one, clears the step count and empties the output
module mutual_inhibition_oscillator_step
    import mio_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // accumulator width: the inhibition sum stays below 2^(mag+16), scaled by a
    // 12 bit step factor plus the shifted old value it stays below 2^(mag+29)
    localparam int MAG_BITS = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam int PW       = MAG_BITS + 30;

    localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    // start value 1.0, clipped when the value width cannot hold it
    localparam logic signed [VALUE_BITS-1:0] START_ONE =
        (VALUE_BITS > 13) ? VALUE_BITS'(ONE_Q) : V_MAX;

    localparam logic signed [PW-1:0] HALF_U = PW'(1) << (2*FRAC - 1);
    localparam logic signed [PW-1:0] HALF_V = PW'(1) << (FRAC - 1);
    localparam logic signed [PW-1:0] D_MAX  = PW'(32767);
    localparam logic signed [PW-1:0] D_MIN  = {{(PW-15){1'b1}}, 15'd0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_WRITE,
        S_OUT
    } t_state;

    // products of one neuron update, in the order they run
    typedef enum logic [2:0] {
        TERM_MUTUAL,
        TERM_ADAPT,
        TERM_FEEDBACK,
        TERM_MEMBRANE,
        TERM_ADAPT_RATE
    } t_term;

    function automatic logic signed [PW-1:0] sx_v(input logic signed [VALUE_BITS-1:0] x);
        return {{(PW-VALUE_BITS){x[VALUE_BITS-1]}}, x};
    endfunction

    function automatic logic signed [PW-1:0] sx_16(input logic signed [15:0] x);
        return {{(PW-16){x[15]}}, x};
    endfunction

    // configuration registers
    logic [14:0]        r_mutual_weight;
    logic [14:0]        r_adapt_gain;
    logic signed [15:0] r_tonic_drive;
    logic signed [15:0] r_feedback_gain;
    logic [11:0]        r_step_over_t1;
    logic [11:0]        r_step_over_t2;
    logic               r_start_phase;

    // control
    t_state          r_state;
    t_term           r_term;
    logic            r_sel;
    logic [3:0]      r_cnt;
    logic            r_clip;
    logic            r_out_valid;

    // serial multiplier
    logic [15:0]           r_ser;
    logic                  r_sgn;
    logic                  r_neg;
    logic signed [PW-1:0]  r_acc;
    logic signed [PW-1:0]  r_mcand;

    // oscillator state
    logic signed [VALUE_BITS-1:0] r_u_one, r_v_one, r_y_one;
    logic signed [VALUE_BITS-1:0] r_u_two, r_v_two, r_y_two;
    logic [COUNT_BITS-1:0]        r_count;

    // per-tick payload
    logic signed [VALUE_BITS-1:0] r_y_old_one, r_y_old_two;
    logic signed [15:0]           r_fb_one, r_fb_two;
    t_out_item                    r_res;
    t_out_item                    r_out;

    // combinational
    logic                         w_in_acc;
    logic                         w_out_room;
    logic                         w_out_load;
    t_out_item                    w_out_next;
    logic signed [VALUE_BITS-1:0] w_u, w_v, w_y, w_y_other;
    logic signed [15:0]           w_fb;
    logic [15:0]                  w_ld_ser;
    logic [3:0]                   w_ld_last;
    logic                         w_ld_sgn;
    logic                         w_ld_neg;
    logic                         w_ld_acc_en;
    logic signed [PW-1:0]         w_ld_acc;
    logic signed [PW-1:0]         w_ld_mcand;
    logic                         w_sub;
    logic signed [PW-1:0]         w_acc_step;
    logic signed [PW-1:0]         w_shifted;
    logic [PW-VALUE_BITS:0]       w_hi;
    logic                         w_fits;
    logic signed [VALUE_BITS-1:0] w_sat_val;
    logic signed [VALUE_BITS-1:0] w_rect;
    logic signed [PW-1:0]         w_y1_x, w_y2_x, w_diff;
    t_out_item                    w_snap;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign w_out_room  = ~r_out_valid | ~i_out_stall;
    assign w_out_load  = (r_state == S_OUT) & w_out_room;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // finished result with the clip flag of the whole step
    always_comb begin
        w_out_next           = r_res;
        w_out_next.saturated = r_clip;
    end

    // operands of the neuron being updated
    assign w_u       = r_sel ? r_u_two : r_u_one;
    assign w_v       = r_sel ? r_v_two : r_v_one;
    assign w_y       = r_sel ? r_y_two : r_y_one;
    // inhibition comes from the other neuron's output before this step
    assign w_y_other = r_sel ? r_y_old_one : r_y_old_two;
    assign w_fb      = r_sel ? r_fb_two : r_fb_one;

    // operand setup of each product: the register goes into the serial shift
    // register, the state, feedback or partial sum value is the parallel multiplicand
    always_comb begin
        w_ld_ser    = '0;
        w_ld_last   = '0;
        w_ld_sgn    = 1'b0;
        w_ld_neg    = 1'b0;
        w_ld_acc_en = 1'b0;
        w_ld_acc    = '0;
        w_ld_mcand  = '0;
        unique case (r_term)
            TERM_MUTUAL: begin
                // acc starts as (tonic - u) in q.24
                w_ld_ser    = {1'b0, r_mutual_weight};
                w_ld_last   = 4'd14;
                w_ld_neg    = 1'b1;
                w_ld_mcand  = sx_v(w_y_other);
                w_ld_acc_en = 1'b1;
                w_ld_acc    = (sx_16(r_tonic_drive) - sx_v(w_u)) <<< FRAC;
            end
            TERM_ADAPT: begin
                w_ld_ser   = {1'b0, r_adapt_gain};
                w_ld_last  = 4'd14;
                w_ld_neg   = 1'b1;
                w_ld_mcand = sx_v(w_v);
            end
            TERM_FEEDBACK: begin
                // signed gain: top bit carries negative weight
                w_ld_ser   = r_feedback_gain;
                w_ld_last  = 4'd15;
                w_ld_sgn   = 1'b1;
                w_ld_neg   = 1'b1;
                w_ld_mcand = sx_16(w_fb);
            end
            TERM_MEMBRANE: begin
                // old value and rounding half folded in ahead of the product
                w_ld_ser    = {4'd0, r_step_over_t1};
                w_ld_last   = 4'd11;
                w_ld_mcand  = r_acc;
                w_ld_acc_en = 1'b1;
                w_ld_acc    = (sx_v(w_u) <<< (2*FRAC)) + HALF_U;
            end
            TERM_ADAPT_RATE: begin
                w_ld_ser    = {4'd0, r_step_over_t2};
                w_ld_last   = 4'd11;
                w_ld_mcand  = sx_v(w_y) - sx_v(w_v);
                w_ld_acc_en = 1'b1;
                w_ld_acc    = (sx_v(w_v) <<< FRAC) + HALF_V;
            end
            default: begin
                w_ld_ser = '0;
            end
        endcase
    end

    // one multiplier bit per cycle
    assign w_sub      = r_neg ^ (r_sgn & (r_cnt == '0));
    assign w_acc_step = r_ser[0] ? (w_sub ? (r_acc - r_mcand) : (r_acc + r_mcand)) : r_acc;

    // scale back and saturate to the value width
    assign w_shifted = (r_term == TERM_MEMBRANE) ? (r_acc >>> (2*FRAC)) : (r_acc >>> FRAC);
    assign w_hi      = w_shifted[PW-1:VALUE_BITS-1];
    assign w_fits    = (&w_hi) | ~(|w_hi);
    assign w_sat_val = w_fits ? w_shifted[VALUE_BITS-1:0] : (w_shifted[PW-1] ? V_MIN : V_MAX);
    assign w_rect    = w_sat_val[VALUE_BITS-1] ? '0 : w_sat_val;

    // report fields, taken from the outputs before the step
    assign w_y1_x = sx_v(r_y_one);
    assign w_y2_x = sx_v(r_y_two);
    assign w_diff = w_y1_x - w_y2_x;

    always_comb begin
        w_snap            = '0;
        w_snap.step_index = 16'(r_count);
        w_snap.output_one = (w_y1_x > D_MAX) ? 15'h7fff : 15'(w_y1_x);
        w_snap.output_two = (w_y2_x > D_MAX) ? 15'h7fff : 15'(w_y2_x);
        if (w_diff > D_MAX) begin
            w_snap.output_difference = 16'sh7fff;
        end else if (w_diff < D_MIN) begin
            w_snap.output_difference = 16'sh8000;
        end else begin
            w_snap.output_difference = 16'(w_diff);
        end
        w_snap.phase_bit = (w_y1_x > w_y2_x);
        w_snap.saturated = 1'b0;
    end

    // configuration registers, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mutual_weight <= RST_MUTUAL_WEIGHT;
            r_adapt_gain    <= RST_ADAPT_GAIN;
            r_tonic_drive   <= RST_TONIC_DRIVE;
            r_feedback_gain <= RST_FEEDBACK_GAIN;
            r_step_over_t1  <= RST_STEP_OVER_T1;
            r_step_over_t2  <= RST_STEP_OVER_T2;
            r_start_phase   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MUTUAL_WEIGHT: r_mutual_weight <= i_cfg_data[14:0];
                CFG_ADAPT_GAIN:    r_adapt_gain    <= i_cfg_data[14:0];
                CFG_TONIC_DRIVE:   r_tonic_drive   <= i_cfg_data;
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data;
                CFG_STEP_OVER_T1:  r_step_over_t1  <= i_cfg_data[11:0];
                CFG_STEP_OVER_T2:  r_step_over_t2  <= i_cfg_data[11:0];
                CFG_START_PHASE:   r_start_phase   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= TERM_MUTUAL;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_u_one     <= START_ONE;
            r_v_one     <= START_ONE;
            r_y_one     <= '0;
            r_u_two     <= '0;
            r_v_two     <= '0;
            r_y_two     <= '0;
            r_count     <= '0;
        end else begin
            // a new result may replace one taken at this same edge
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.restart) begin
                            r_u_one <= r_start_phase ? '0 : START_ONE;
                            r_v_one <= r_start_phase ? '0 : START_ONE;
                            r_y_one <= '0;
                            r_u_two <= r_start_phase ? START_ONE : '0;
                            r_v_two <= r_start_phase ? START_ONE : '0;
                            r_y_two <= '0;
                            r_count <= '0;
                            r_res   <= '0;
                            r_clip  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_y_old_one <= r_y_one;
                            r_y_old_two <= r_y_two;
                            r_fb_one    <= i_in_data.feedback_one;
                            r_fb_two    <= i_in_data.feedback_two;
                            r_res       <= w_snap;
                            r_clip      <= 1'b0;
                            r_sel       <= 1'b0;
                            r_term      <= TERM_MUTUAL;
                            r_state     <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_ser   <= w_ld_ser;
                    r_cnt   <= w_ld_last;
                    r_sgn   <= w_ld_sgn;
                    r_neg   <= w_ld_neg;
                    r_mcand <= w_ld_mcand;
                    if (w_ld_acc_en) begin
                        r_acc <= w_ld_acc;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc   <= w_acc_step;
                    r_ser   <= r_ser >> 1;
                    r_mcand <= r_mcand <<< 1;
                    r_cnt   <= r_cnt - 4'd1;
                    if (r_cnt == '0) begin
                        unique case (r_term)
                            TERM_MUTUAL: begin
                                r_term  <= TERM_ADAPT;
                                r_state <= S_LOAD;
                            end
                            TERM_ADAPT: begin
                                r_term  <= TERM_FEEDBACK;
                                r_state <= S_LOAD;
                            end
                            TERM_FEEDBACK: begin
                                r_term  <= TERM_MEMBRANE;
                                r_state <= S_LOAD;
                            end
                            default: begin
                                r_state <= S_WRITE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    r_clip <= r_clip | ~w_fits;
                    if (r_term == TERM_MEMBRANE) begin
                        if (r_sel) begin
                            r_u_two <= w_sat_val;
                            r_y_two <= w_rect;
                        end else begin
                            r_u_one <= w_sat_val;
                            r_y_one <= w_rect;
                        end
                        r_term  <= TERM_ADAPT_RATE;
                        r_state <= S_LOAD;
                    end else begin
                        if (r_sel) begin
                            r_v_two <= w_sat_val;
                            r_count <= r_count + COUNT_BITS'(1);
                            r_state <= S_OUT;
                        end else begin
                            r_v_one <= w_sat_val;
                            r_sel   <= 1'b1;
                            r_term  <= TERM_MUTUAL;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_room) begin
                        r_out   <= w_out_next;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_restart_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.restart) |=> (r_state == S_OUT && r_count == '0))
        else $error("restart tick did not go straight to the result");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in_data.restart) |=>
        (r_state == S_LOAD && r_term == TERM_MUTUAL && !r_sel))
        else $error("step tick did not start at the first neuron's first product");

    a_count_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_term == TERM_ADAPT_RATE && r_sel) |=>
        (r_state == S_OUT && r_count == $past(r_count) + COUNT_BITS'(1)))
        else $error("step count did not advance at the end of a step");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output register filled outside the result state");

endmodule

/* dv/mutual_inhibition_oscillator_step_tb.sv */
// self-checking testbench for the two-neuron mutual inhibition oscillator step block
module mutual_inhibition_oscillator_step_tb;
    import mio_pkg::*;

    // run shape
    localparam int  RANDOM_PHASES   = 13;
    localparam int  TICKS_PER_PHASE = 132;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  END_CYCLES      = 200;
    localparam int  MAX_REPORTS     = 10;
    // slowest run is about 1750 ticks, each with the longest step, idle gap and
    // receiver stall; the limit takes that several times over
    localparam int  CYCLE_LIMIT     = 6_000_000;

    localparam longint Q_MAX = 32767;
    localparam longint Q_MIN = -32768;

    // register index with no register behind it, writes there are dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    // one full set of oscillator registers
    typedef struct packed {
        logic [14:0]        mutual_weight;
        logic [14:0]        adapt_gain;
        logic signed [15:0] tonic_drive;
        logic signed [15:0] feedback_gain;
        logic [11:0]        step_over_t1;
        logic [11:0]        step_over_t2;
        logic               start_phase;
    } t_osc_settings;

    // ports
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // register copy and neuron state of the predictor
    t_osc_settings      osc_cfg;
    logic signed [15:0] membrane_one, adaptation_one, rectified_one;
    logic signed [15:0] membrane_two, adaptation_two, rectified_two;
    logic [15:0]        step_count;

    // predicted tick results, oldest first
    t_out_item expected_ticks[$];

    // bookkeeping
    int  mismatch_count    = 0;
    int  ticks_sent        = 0;
    int  restarts_sent     = 0;
    int  clipped_ticks     = 0;
    int  settings_applied  = 0;
    int  cycle_count       = 0;
    bit  no_idle           = 1'b0;

    mutual_inhibition_oscillator_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // oscillator predictor
    // ------------------------------------------------------------------

    function automatic logic signed [15:0] clip_q412(input longint x, inout bit hit);
        if (x > Q_MAX) begin
            hit = 1'b1;
            return 16'sh7FFF;
        end
        if (x < Q_MIN) begin
            hit = 1'b1;
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    // add half then floor, arithmetic shift floors negative values
    function automatic longint round_shift(input longint x, input int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic void reload_start_state();
        logic signed [15:0] one_q;
        one_q = 16'(ONE_Q);
        membrane_one   = osc_cfg.start_phase ? 16'sd0 : one_q;
        adaptation_one = osc_cfg.start_phase ? 16'sd0 : one_q;
        membrane_two   = osc_cfg.start_phase ? one_q : 16'sd0;
        adaptation_two = osc_cfg.start_phase ? one_q : 16'sd0;
        rectified_one  = 16'sd0;
        rectified_two  = 16'sd0;
        step_count     = 16'd0;
    endfunction

    // one euler step of one neuron, inhibited by the other neuron's old output
    function automatic void advance_neuron(inout logic signed [15:0] u, v, y,
                                           input logic signed [15:0] y_other, fb,
                                           inout bit hit);
        longint             drive;
        logic signed [15:0] u_next, y_next;
        drive = (longint'(osc_cfg.tonic_drive) - longint'(u)) * ONE_Q
              - longint'(osc_cfg.mutual_weight) * longint'(y_other)
              - longint'(osc_cfg.adapt_gain) * longint'(v)
              - longint'(osc_cfg.feedback_gain) * longint'(fb);
        u_next = clip_q412(longint'(u)
                 + round_shift(longint'(osc_cfg.step_over_t1) * drive, 2 * FRAC), hit);
        y_next = (u_next > 16'sd0) ? u_next : 16'sd0;
        v = clip_q412(longint'(v) + round_shift(longint'(osc_cfg.step_over_t2)
                      * (longint'(y_next) - longint'(v)), FRAC), hit);
        u = u_next;
        y = y_next;
    endfunction

    // result of one tick, and the state it leaves behind
    function automatic t_out_item predict_tick(input t_in_item tick);
        t_out_item          res;
        logic signed [15:0] y1, y2;
        bit                 hit;
        res = '0;
        hit = 1'b0;
        if (tick.restart) begin
            // feedback ignored, everything reported as zero
            reload_start_state();
            return res;
        end
        y1 = rectified_one;
        y2 = rectified_two;
        res.step_index        = step_count;
        res.output_one        = y1[14:0];
        res.output_two        = y2[14:0];
        res.output_difference = y1 - y2;   // both outputs are non-negative, no overflow
        res.phase_bit         = (y1 > y2);
        advance_neuron(membrane_one, adaptation_one, rectified_one, y2,
                       tick.feedback_one, hit);
        advance_neuron(membrane_two, adaptation_two, rectified_two, y1,
                       tick.feedback_two, hit);
        res.saturated = hit;
        step_count    = step_count + 16'd1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 30);
        return $urandom_range(60, 400);
    endfunction

    // value in [lo, hi], with the two ends picked often
    function automatic int draw_setting(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_in_item tick_of(input bit restart, input int fb1, input int fb2);
        t_in_item tick;
        tick.restart      = restart;
        tick.feedback_one = 16'(fb1);
        tick.feedback_two = 16'(fb2);
        return tick;
    endfunction

    // mostly plain steps with moderate feedback so the pair keeps oscillating
    function automatic t_in_item random_tick();
        int fb1, fb2;
        fb1 = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 4095)) - 2048;
        fb2 = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 4095)) - 2048;
        return tick_of($urandom_range(0, 99) < 2, fb1, fb2);
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one transfer on the tick channel; valid stays up afterwards until the
    // next call or a drain lowers it, so back-to-back ticks never glitch
    task automatic send_tick(input t_in_item tick);
        int        gap;
        t_out_item res;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // transfer taken at this edge
        res = predict_tick(tick);
        expected_ticks.push_back(res);
        ticks_sent++;
        if (tick.restart) restarts_sent++;
        if (res.saturated) clipped_ticks++;
    endtask

    // let everything in flight come out so registers can be changed safely
    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write at the next edge; write enable is left high for chaining
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_MUTUAL_WEIGHT: osc_cfg.mutual_weight = value[14:0];
            CFG_ADAPT_GAIN:    osc_cfg.adapt_gain    = value[14:0];
            CFG_TONIC_DRIVE:   osc_cfg.tonic_drive   = value;
            CFG_FEEDBACK_GAIN: osc_cfg.feedback_gain = value;
            CFG_STEP_OVER_T1:  osc_cfg.step_over_t1  = value[11:0];
            CFG_STEP_OVER_T2:  osc_cfg.step_over_t2  = value[11:0];
            CFG_START_PHASE:   osc_cfg.start_phase   = value[0];
            default: ;   // no register there
        endcase
    endtask

    // all seven registers back to back, optionally a stray write to a hole
    task automatic apply_settings(input t_osc_settings s, input bit poke_unused);
        write_register(CFG_MUTUAL_WEIGHT, 16'(s.mutual_weight));
        write_register(CFG_ADAPT_GAIN,    16'(s.adapt_gain));
        write_register(CFG_TONIC_DRIVE,   s.tonic_drive);
        write_register(CFG_FEEDBACK_GAIN, s.feedback_gain);
        write_register(CFG_STEP_OVER_T1,  16'(s.step_over_t1));
        write_register(CFG_STEP_OVER_T2,  16'(s.step_over_t2));
        write_register(CFG_START_PHASE,   16'(s.start_phase));
        if (poke_unused) write_register(CFG_UNUSED_INDEX, 16'hFFFF);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // receiver side: random stall bursts between runs of open cycles
    initial begin : out_stall_driver
        int hold;
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            hold = idle_len();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge clk) begin : check_results
        t_out_item want;
        bit        bad;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_ticks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: step %0d y1 %0d y2 %0d diff %0d",
                             out_data.step_index, out_data.output_one,
                             out_data.output_two, out_data.output_difference);
            end else begin
                want = expected_ticks.pop_front();
                bad  = (out_data.step_index        !== want.step_index)
                    || (out_data.output_one        !== want.output_one)
                    || (out_data.output_two        !== want.output_two)
                    || (out_data.output_difference !== want.output_difference)
                    || (out_data.phase_bit         !== want.phase_bit)
                    || (out_data.saturated         !== want.saturated);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"tick mismatch: expected step %0d y1 %0d y2 %0d diff %0d ",
                                  "phase %0b sat %0b, actual step %0d y1 %0d y2 %0d ",
                                  "diff %0d phase %0b sat %0b"},
                                 want.step_index, want.output_one, want.output_two,
                                 want.output_difference, want.phase_bit, want.saturated,
                                 out_data.step_index, out_data.output_one,
                                 out_data.output_two, out_data.output_difference,
                                 out_data.phase_bit, out_data.saturated);
                end
            end
        end
    end

    // cycle counter and watchdog
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[mutual_inhibition_oscillator_step] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset defaults: first neuron starts at one, feedback gain is zero so
    // even extreme feedback has no effect; restart in the middle of a run
    task automatic test_reset_state();
        repeat (6) send_tick(tick_of(1'b0, 0, 0));
        send_tick(tick_of(1'b0, 32767, -32768));
        send_tick(tick_of(1'b0, -32768, 32767));
        send_tick(tick_of(1'b1, 1234, -1));
        send_tick(tick_of(1'b0, 0, 0));
    endtask

    // register extremes, clipping in both directions, start phase one,
    // a write to an index with no register, back-to-back restarts
    task automatic test_register_extremes();
        t_osc_settings s;

        // everything large, second neuron starts
        s = '{mutual_weight: 15'h7FFF, adapt_gain: 15'h7FFF, tonic_drive: 16'sh7FFF,
              feedback_gain: 16'sh8000, step_over_t1: 12'hFFF, step_over_t2: 12'hFFF,
              start_phase: 1'b1};
        drain_ticks();
        apply_settings(s, 1'b1);
        send_tick(tick_of(1'b1, 0, 0));
        send_tick(tick_of(1'b0, -32768, 32767));
        send_tick(tick_of(1'b0, 32767, -32768));
        send_tick(tick_of(1'b0, 0, -1));
        send_tick(tick_of(1'b0, 0, 0));

        // everything at its low end but the feedback gain at its top, the neurons do not move
        s = '{mutual_weight: 15'h0, adapt_gain: 15'h0, tonic_drive: 16'sh8000,
              feedback_gain: 16'sh7FFF, step_over_t1: 12'h0, step_over_t2: 12'h0,
              start_phase: 1'b0};
        drain_ticks();
        apply_settings(s, 1'b0);
        send_tick(tick_of(1'b1, 0, 0));
        send_tick(tick_of(1'b1, -1, -1));
        send_tick(tick_of(1'b0, 32767, 32767));
        send_tick(tick_of(1'b0, -32768, -1));

        // strongest negative drive with fast steps, clips toward the floor
        s = '{mutual_weight: 15'h7FFF, adapt_gain: 15'h0, tonic_drive: 16'sh8000,
              feedback_gain: 16'sh7FFF, step_over_t1: 12'hFFF, step_over_t2: 12'hFFF,
              start_phase: 1'b1};
        drain_ticks();
        apply_settings(s, 1'b0);
        send_tick(tick_of(1'b1, 0, 0));
        send_tick(tick_of(1'b0, 32767, -32768));
        send_tick(tick_of(1'b0, 1, -2));
        send_tick(tick_of(1'b0, 0, 0));
    endtask

    // long oscillation runs under random registers: even phases stay near the
    // usual operating point, odd ones roam the full ranges; two phases run
    // without any idle cycles on either side
    task automatic test_random_oscillation();
        t_osc_settings s;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase % 2 == 0) begin
                s.mutual_weight = 15'(draw_setting(4096, 16383));
                s.adapt_gain    = 15'(draw_setting(4096, 16383));
                s.tonic_drive   = 16'(draw_setting(0, 8191));
                s.feedback_gain = 16'(draw_setting(-2048, 2048));
                s.step_over_t1  = 12'(draw_setting(100, 800));
                s.step_over_t2  = 12'(draw_setting(50, 400));
            end else begin
                s.mutual_weight = 15'(draw_setting(0, 32767));
                s.adapt_gain    = 15'(draw_setting(0, 32767));
                s.tonic_drive   = 16'(draw_setting(-32768, 32767));
                s.feedback_gain = 16'(draw_setting(-32768, 32767));
                s.step_over_t1  = 12'(draw_setting(0, 4095));
                s.step_over_t2  = 12'(draw_setting(0, 4095));
            end
            s.start_phase = 1'($urandom_range(0, 1));
            drain_ticks();
            apply_settings(s, 1'b0);
            no_idle = (phase == 4) || (phase == RANDOM_PHASES - 1);
            // each run opens with a restart so it starts from a clean state
            send_tick(tick_of(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535)));
            repeat (TICKS_PER_PHASE) send_tick(random_tick());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin : main_sequence
        // predictor starts from the reset registers and start state
        osc_cfg = '{mutual_weight: RST_MUTUAL_WEIGHT, adapt_gain: RST_ADAPT_GAIN,
                    tonic_drive: RST_TONIC_DRIVE, feedback_gain: RST_FEEDBACK_GAIN,
                    step_over_t1: RST_STEP_OVER_T1, step_over_t2: RST_STEP_OVER_T2,
                    start_phase: 1'b0};
        reload_start_state();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_random_oscillation();

        drain_ticks();
        repeat (END_CYCLES) @(posedge clk);

        $display("ran %0d ticks (%0d restarts) under %0d register settings",
                 ticks_sent, restarts_sent, settings_applied);
        $display("%0d ticks clipped a state value, %0d mismatches",
                 clipped_ticks, mismatch_count);
        if (mismatch_count == 0 && expected_ticks.size() == 0) begin
            $display("[mutual_inhibition_oscillator_step] OK");
        end else begin
            $display("[mutual_inhibition_oscillator_step] ERROR");
        end
        $finish;
    end

endmodule
